// ----- rtl/rbsi_pkg.sv -----
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants of the ray/box slab intersection pipeline.
// ----------------------------------------------------------------------------
package rbsi_pkg;

   localparam int T_W         = 32;
   localparam int DIFF_W      = T_W + 1;
   localparam int NUM_AXES    = 3;
   localparam int NUM_CORNERS = 2 * NUM_AXES;
   localparam int REQ_DATA_W  = NUM_CORNERS * T_W;
   localparam int RSP_DATA_W  = 72;
   localparam int RSP_PAD_W   = RSP_DATA_W - (2 * T_W + 2);
   localparam int CSR_ADDR_W  = 3;

   // quotient bits resolved, one per stage, plus entry and saturation stages
   localparam int DIV_STEPS   = T_W;
   localparam int DIV_LAT     = DIV_STEPS + 2;
   // entry stage, divider, order, two compare stages, output register
   localparam int PIPE_DEPTH  = DIV_LAT + 5;

   localparam logic signed [T_W-1:0] T_MAX = {1'b0, {(T_W-1){1'b1}}};
   localparam logic signed [T_W-1:0] T_MIN = {1'b1, {(T_W-1){1'b0}}};

   localparam logic [T_W-1:0] ONE_FIXED_RESET = 32'h0001_0000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_ORIGIN_X = 3'd0,
      REG_ORIGIN_Y = 3'd1,
      REG_ORIGIN_Z = 3'd2,
      REG_DIR_X    = 3'd3,
      REG_DIR_Y    = 3'd4,
      REG_DIR_Z    = 3'd5,
      REG_T_START  = 3'd6,
      REG_T_LIMIT  = 3'd7
   } csr_index_type;

endpackage

// ----- rtl/rbsi_divider.sv -----
// ----------------------------------------------------------------------------
// rbsi_divider
// Pipelined slab parameter unit: (diff * 2^FRAC_BITS) / dir, truncated toward
// zero and clamped to the signed 32-bit range, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rbsi_divider
   import rbsi_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [DIFF_W-1:0] diff,
   input  logic [T_W-1:0]          dir_mag,
   input  logic                    dir_neg,
   output logic signed [T_W-1:0]   t_val,
   output logic                    sat
);

   localparam int NUM_W = T_W + FRAC_BITS;

   logic [T_W-1:0]   diff_mag;
   logic [NUM_W-1:0] num;
   logic [T_W-1:0]   rem_init;

   logic [T_W-1:0]   rem_ff [DIV_STEPS+1];
   logic [T_W-1:0]   low_ff [DIV_STEPS+1];
   logic             neg_ff [DIV_STEPS+1];
   logic             big_ff [DIV_STEPS+1];
   logic [T_W-1:0]   rem_in [DIV_STEPS];
   logic [T_W-1:0]   low_in [DIV_STEPS];

   logic signed [T_W-1:0] t_ff, t_in;
   logic                  sat_ff, sat_in;

   always_comb begin
      diff_mag = diff[DIFF_W-1] ? T_W'(-diff) : T_W'(diff);
      num      = {diff_mag, {FRAC_BITS{1'b0}}};
      rem_init = T_W'(num[NUM_W-1:T_W]);
   end

   always_comb begin
      logic [T_W:0] trial;
      logic         ge;
      for (int s = 0; s < DIV_STEPS; s++) begin
         trial     = {rem_ff[s], low_ff[s][T_W-1]};
         ge        = (trial >= {1'b0, dir_mag});
         rem_in[s] = ge ? T_W'(trial - {1'b0, dir_mag}) : trial[T_W-1:0];
         low_in[s] = {low_ff[s][T_W-2:0], ge};
      end
   end

   always_comb begin
      logic [T_W-1:0] qmag;
      qmag   = low_ff[DIV_STEPS];
      sat_in = 1'b0;
      if (big_ff[DIV_STEPS]) begin
         sat_in = 1'b1;
         t_in   = neg_ff[DIV_STEPS] ? T_MIN : T_MAX;
      end else if (!neg_ff[DIV_STEPS]) begin
         if (qmag[T_W-1]) begin
            sat_in = 1'b1;
            t_in   = T_MAX;
         end else begin
            t_in   = $signed(qmag);
         end
      end else if (qmag > T_W'(T_MIN)) begin
         sat_in = 1'b1;
         t_in   = T_MIN;
      end else begin
         t_in   = $signed(~qmag + T_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= rem_init;
         low_ff[0] <= num[T_W-1:0];
         neg_ff[0] <= diff[DIFF_W-1] ^ dir_neg;
         big_ff[0] <= (rem_init >= dir_mag);
         for (int s = 0; s < DIV_STEPS; s++) begin
            rem_ff[s+1] <= rem_in[s];
            low_ff[s+1] <= low_in[s];
            neg_ff[s+1] <= neg_ff[s];
            big_ff[s+1] <= big_ff[s];
         end
         t_ff   <= t_in;
         sat_ff <= sat_in;
      end
   end

   assign t_val = t_ff;
   assign sat   = sat_ff;

endmodule

// ----- rtl/ray_box_slab_intersect.sv -----
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Slab test of one configured ray against a stream of axis-aligned boxes.
// ----------------------------------------------------------------------------
// Usage:
//   Write the ray origin, direction and [t_start, t_limit] through the csr_
//   port while no box is in flight. Each req_ beat carries one box as signed
//   fixed-point min and max corners; each rsp_ beat returns hit, the narrowed
//   interval (zero on a miss) and a flag set when any slab t was clamped.
//   One response beat per request beat, in order.
// Pipeline:
//   One box is taken per cycle while the pipeline is not stalled. The depth
//   is set by the slab divider, which resolves one quotient bit per pipeline
//   stage.
// Reset:
//   Clears the pipeline valid bits and the skid valid bit and loads the
//   register reset values (direction +1.0 on x, interval [0, max]).
// Stall:
//   While rsp_tready is low and a response waits, the whole pipeline holds;
//   one more request beat is still taken into a skid register, after which
//   req_tready drops until the pipeline moves again.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect
   import rbsi_pkg::*;
#(
   parameter int PARALLEL_EPS = 1,
   parameter int FRAC_BITS    = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   // req_tdata: box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // rsp_tdata: hit, t_near, t_far, saturated, zero fill
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [T_W-1:0]        csr_wdata
);

   logic signed [T_W-1:0] org_ff [NUM_AXES];
   logic signed [T_W-1:0] dir_ff [NUM_AXES];
   logic signed [T_W-1:0] t_start_ff, t_limit_ff;

   logic [T_W-1:0] dir_mag [NUM_AXES];
   logic           dir_neg [NUM_AXES];
   logic           par     [NUM_AXES];
   logic           any_np;

   logic                  skid_valid_ff, skid_valid_in;
   logic [REQ_DATA_W-1:0] skid_data_ff;
   logic                  req_acc, pipe_en, src_valid;
   logic [REQ_DATA_W-1:0] src_data;

   logic                    vld_ff  [PIPE_DEPTH];
   logic                    miss_ff [DIV_LAT+1];
   logic                    miss_in;
   logic signed [DIFF_W-1:0] diff_ff [NUM_CORNERS];
   logic signed [DIFF_W-1:0] diff_in [NUM_CORNERS];

   logic signed [T_W-1:0] q_t   [NUM_CORNERS];
   logic                  q_sat [NUM_CORNERS];

   logic signed [T_W-1:0] tmin_ff [NUM_AXES], tmin_in [NUM_AXES];
   logic signed [T_W-1:0] tmax_ff [NUM_AXES], tmax_in [NUM_AXES];
   logic                  sat2_ff, sat2_in, miss2_ff;
   logic signed [T_W-1:0] lo_a_ff, lo_b_ff, hi_a_ff, hi_b_ff;
   logic                  sat3_ff, miss3_ff;
   logic signed [T_W-1:0] lo_ff, hi_ff;
   logic                  sat4_ff, miss4_ff;
   logic                  hit_in;
   logic                  hit_ff, sat_ff;
   logic signed [T_W-1:0] near_ff, far_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            org_ff[a] <= '0;
            dir_ff[a] <= (a == 0) ? ONE_FIXED_RESET : '0;
         end
         t_start_ff <= '0;
         t_limit_ff <= T_MAX;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            REG_ORIGIN_X: org_ff[0]  <= csr_wdata;
            REG_ORIGIN_Y: org_ff[1]  <= csr_wdata;
            REG_ORIGIN_Z: org_ff[2]  <= csr_wdata;
            REG_DIR_X:    dir_ff[0]  <= csr_wdata;
            REG_DIR_Y:    dir_ff[1]  <= csr_wdata;
            REG_DIR_Z:    dir_ff[2]  <= csr_wdata;
            REG_T_START:  t_start_ff <= csr_wdata;
            REG_T_LIMIT:  t_limit_ff <= csr_wdata;
            default:      t_limit_ff <= t_limit_ff;
         endcase
      end
   end

   always_comb begin
      any_np = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
         dir_neg[a] = dir_ff[a][T_W-1];
         dir_mag[a] = dir_neg[a] ? (~dir_ff[a] + T_W'(1)) : dir_ff[a];
         par[a]     = (dir_mag[a] == '0) || (dir_mag[a] < T_W'(PARALLEL_EPS));
         any_np     = any_np | ~par[a];
      end
   end

   // input skid and pipeline advance
   assign pipe_en    = !vld_ff[PIPE_DEPTH-1] || rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign req_acc    = req_tvalid && req_tready;
   assign src_valid  = skid_valid_ff || req_acc;
   assign src_data   = skid_valid_ff ? skid_data_ff : req_tdata;
   assign skid_valid_in = !pipe_en && src_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         skid_data_ff <= req_tdata;
      end
   end

   // entry stage: corner minus origin, parallel-slab rejection
   always_comb begin
      logic signed [T_W-1:0] corner [NUM_CORNERS];
      logic                  outside;
      miss_in = 1'b0;
      for (int i = 0; i < NUM_CORNERS; i++) begin
         corner[i]  = $signed(src_data[i*T_W +: T_W]);
         diff_in[i] = DIFF_W'(corner[i]) - DIFF_W'(org_ff[i % NUM_AXES]);
      end
      for (int a = 0; a < NUM_AXES; a++) begin
         outside = (org_ff[a] < corner[a]) || (org_ff[a] > corner[a+NUM_AXES]);
         miss_in = miss_in | (par[a] & outside);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_DEPTH; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (pipe_en) begin
         vld_ff[0] <= src_valid;
         for (int k = 1; k < PIPE_DEPTH; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < NUM_CORNERS; gi++) begin : g_div
         rbsi_divider #(
            .FRAC_BITS(FRAC_BITS)
         ) u_div (
            .clock   (clock),
            .en      (pipe_en),
            .diff    (diff_ff[gi]),
            .dir_mag (dir_mag[gi % NUM_AXES]),
            .dir_neg (dir_neg[gi % NUM_AXES]),
            .t_val   (q_t[gi]),
            .sat     (q_sat[gi])
         );
      end
   endgenerate

   // order each slab; a parallel slab leaves the interval as is
   always_comb begin
      sat2_in = 1'b0;
      for (int a = 0; a < NUM_AXES; a++) begin
         if (par[a]) begin
            tmin_in[a] = T_MIN;
            tmax_in[a] = T_MAX;
         end else begin
            sat2_in = sat2_in | q_sat[a] | q_sat[a+NUM_AXES];
            if (q_t[a] > q_t[a+NUM_AXES]) begin
               tmin_in[a] = q_t[a+NUM_AXES];
               tmax_in[a] = q_t[a];
            end else begin
               tmin_in[a] = q_t[a];
               tmax_in[a] = q_t[a+NUM_AXES];
            end
         end
      end
   end

   assign hit_in = !miss4_ff && (!any_np || (lo_ff <= hi_ff));

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         diff_ff    <= diff_in;
         miss_ff[0] <= miss_in;
         for (int k = 1; k <= DIV_LAT; k++) begin
            miss_ff[k] <= miss_ff[k-1];
         end
         tmin_ff  <= tmin_in;
         tmax_ff  <= tmax_in;
         sat2_ff  <= sat2_in;
         miss2_ff <= miss_ff[DIV_LAT];
         lo_a_ff  <= (tmin_ff[0] > t_start_ff) ? tmin_ff[0] : t_start_ff;
         lo_b_ff  <= (tmin_ff[1] > tmin_ff[2]) ? tmin_ff[1] : tmin_ff[2];
         hi_a_ff  <= (tmax_ff[0] < t_limit_ff) ? tmax_ff[0] : t_limit_ff;
         hi_b_ff  <= (tmax_ff[1] < tmax_ff[2]) ? tmax_ff[1] : tmax_ff[2];
         sat3_ff  <= sat2_ff;
         miss3_ff <= miss2_ff;
         lo_ff    <= (lo_a_ff > lo_b_ff) ? lo_a_ff : lo_b_ff;
         hi_ff    <= (hi_a_ff < hi_b_ff) ? hi_a_ff : hi_b_ff;
         sat4_ff  <= sat3_ff;
         miss4_ff <= miss3_ff;
         hit_ff   <= hit_in;
         near_ff  <= hit_in ? lo_ff : '0;
         far_ff   <= hit_in ? hi_ff : '0;
         sat_ff   <= sat4_ff;
      end
   end

   assign rsp_tvalid = vld_ff[PIPE_DEPTH-1];
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, sat_ff, far_ff, near_ff, hit_ff};

   // checks
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !hit_ff |-> (near_ff == '0) && (far_ff == '0))
      else $error("miss response carries a nonzero interval");

   a_hit_ordered: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && hit_ff && any_np |-> (near_ff <= far_ff))
      else $error("hit with an inverted narrowed interval");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(vld_ff[0]) && $stable(vld_ff[PIPE_DEPTH-1]))
      else $error("pipeline moved while stalled");

   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(!pipe_en && req_acc))
      else $error("skid register filled without a stall");

endmodule
